[sv/vrra_pkg.sv]
// shared types and constants for the variable record ring allocator
package vrra_pkg;

  localparam int AMOUNT_W = 18;
  localparam int OFFSET_W = 17;
  localparam int LENGTH_W = 18;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

endpackage

[sv/variable_record_ring_allocator_unit.sv]
// top level of the variable record ring allocator: space bookkeeping for a ring buffer
// an accepted word passes through the input register and then the result register
// throughput: one word per cycle unless out_stall holds; the position update is a
// single pass of compares and subtractions between input and result registers
// reset: synchronous, clears read position, write position and wrap mark to zero
// and empties both the input register and the result register
module variable_record_ring_allocator_unit #(
  parameter int CAPACITY = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [vrra_pkg::AMOUNT_W-1:0] amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vrra_pkg::status_t             status,
  output logic [vrra_pkg::OFFSET_W-1:0] offset,
  output logic [vrra_pkg::LENGTH_W-1:0] length
);
  import vrra_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = ((PW > AMOUNT_W) ? PW : AMOUNT_W) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [PW-1:0] read_position;
  logic [PW-1:0] write_position;
  logic [PW-1:0] wrap_mark;

  logic                in_full;
  logic                fn_q;
  logic [AMOUNT_W-1:0] amt_q;

  logic out_load;
  logic step;

  logic [CW-1:0] rp;
  logic [CW-1:0] wp;
  logic [CW-1:0] wm;
  logic [CW-1:0] amt;
  logic [CW-1:0] r_eff;
  logic [CW-1:0] wm_eff;
  logic [CW-1:0] avail;
  logic [CW-1:0] len;
  logic [CW-1:0] start;
  logic [CW-1:0] rp_next;
  logic [CW-1:0] wp_next;
  logic [CW-1:0] wm_next;
  status_t       st;

  assign out_load = !out_valid || !out_stall;
  assign in_stall = in_full && !out_load;
  assign step     = in_full && out_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      fn_q  <= func;
      amt_q <= amount;
    end
  end

  assign rp  = CW'(read_position);
  assign wp  = CW'(write_position);
  assign wm  = CW'(wrap_mark);
  assign amt = CW'(amt_q);

  always_comb begin
    rp_next = rp;
    wp_next = wp;
    wm_next = wm;
    st      = ST_OK;
    start   = '0;
    len     = '0;
    r_eff   = rp;
    wm_eff  = wm;
    avail   = '0;
    if (fn_q == FUNC_PUSH) begin
      if (wp >= rp) begin
        if (CAP_C - wp >= amt) begin
          start   = wp;
          len     = amt;
          wp_next = wp + amt;
        end else if (rp > amt) begin
          wm_next = wp;
          wp_next = amt;
          len     = amt;
        end else begin
          st = ST_FULL;
        end
      end else if (rp - wp > amt) begin
        start   = wp;
        len     = amt;
        wp_next = wp + amt;
      end else begin
        st = ST_FULL;
      end
    end else begin
      if (wp == rp) begin
        st = ST_EMPTY;
      end else begin
        // wrap back to the start once the mark is reached
        if (rp == wm) begin
          r_eff   = '0;
          wm_eff  = '0;
          rp_next = '0;
          wm_next = '0;
        end
        if (wp == r_eff) begin
          st = ST_EMPTY;
        end else begin
          if (wp > r_eff) begin
            avail = wp - r_eff;
          end else if (wm_eff > r_eff) begin
            avail = wm_eff - r_eff;
          end
          len     = (avail < amt) ? avail : amt;
          start   = r_eff;
          rp_next = r_eff + len;
        end
      end
    end
  end

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      read_position  <= '0;
      write_position <= '0;
      wrap_mark      <= '0;
    end else if (step) begin
      read_position  <= rp_next[PW-1:0];
      write_position <= wp_next[PW-1:0];
      wrap_mark      <= wm_next[PW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status <= st;
      offset <= (start >= CAP_C) ? '0 : start[OFFSET_W-1:0];
      length <= len[LENGTH_W-1:0];
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(read_position) <= CAP_C) && (CW'(write_position) <= CAP_C)
    && (CW'(wrap_mark) <= CAP_C))
    else $error("position beyond buffer capacity");

  a_wrap_order: assert property (@(posedge clk) disable iff (rst)
    (wrap_mark != '0) |-> (write_position < read_position))
    else $error("write position caught up with read position while wrapped");

  a_wrap_read: assert property (@(posedge clk) disable iff (rst)
    (wrap_mark != '0) |-> (read_position <= wrap_mark))
    else $error("read position passed the wrap mark");

  a_refused_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (length == '0))
    else $error("refused word carries a length");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
    else $error("undefined status code");

endmodule

[test/variable_record_ring_allocator_unit_test.sv]
// testbench for the ring allocator: directed table and random words against a space predictor
`timescale 1ns / 1ps

module variable_record_ring_allocator_unit_test;
  import vrra_pkg::*;

  localparam int unsigned RING_BYTES = 131072;
  localparam int N_RANDOM = 930;
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
  } grant_t;

  typedef struct packed {
    logic                func;
    logic [AMOUNT_W-1:0] amount;
    logic                fixed;
    grant_t              grant;
  } table_row_t;

  localparam int N_TABLE = 21;

  table_row_t directed_rows [N_TABLE] = '{
    '{FUNC_PULL, 18'd5,      1'b1, '{ST_EMPTY, 17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd0,      1'b1, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd131072, 1'b1, '{ST_OK,    17'd0, 18'd131072}},
    '{FUNC_PUSH, 18'd0,      1'b1, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd1,      1'b1, '{ST_FULL,  17'd0, 18'd0}},
    '{FUNC_PULL, 18'd0,      1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PULL, 18'd100000, 1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd50000,  1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd50000,  1'b1, '{ST_FULL,  17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd49999,  1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PULL, 18'd131072, 1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PULL, 18'd10,     1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PULL, 18'd131072, 1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PULL, 18'd1,      1'b1, '{ST_EMPTY, 17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd131072, 1'b1, '{ST_FULL,  17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd31073,  1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd99998,  1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PULL, 18'd1,      1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PUSH, 18'd131071, 1'b1, '{ST_FULL,  17'd0, 18'd0}},
    '{FUNC_PULL, 18'd131071, 1'b0, '{ST_OK,    17'd0, 18'd0}},
    '{FUNC_PULL, 18'd131072, 1'b0, '{ST_OK,    17'd0, 18'd0}}
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [AMOUNT_W-1:0] amount;
  logic                out_valid;
  logic                out_stall;
  status_t             status;
  logic [OFFSET_W-1:0] offset;
  logic [LENGTH_W-1:0] length;

  logic                word_fixed;
  grant_t              word_fixed_grant;

  logic [17:0] read_pos;
  logic [17:0] write_pos;
  logic [17:0] wrap_at;

  grant_t pending_grants [$];
  int     errors;
  int     cycles;
  bit     long_hold_go;
  bit     long_hold_done;
  bit     quiet_tail;

  variable_record_ring_allocator_unit #(.CAPACITY(RING_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .amount(amount),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .offset(offset),
    .length(length)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic grant_t ring_grant(logic f, logic [AMOUNT_W-1:0] amt);
    int unsigned rd;
    int unsigned wr;
    int unsigned wm;
    int unsigned sz;
    int unsigned start;
    int unsigned len;
    status_t     st;
    grant_t      g;
    rd = 32'(read_pos);
    wr = 32'(write_pos);
    wm = 32'(wrap_at);
    sz = 32'(amt);
    start = 0;
    len = 0;
    st = ST_FULL;
    if (f == FUNC_PUSH) begin
      if (wr >= rd) begin
        if (RING_BYTES - wr >= sz) begin
          st = ST_OK; start = wr; len = sz; wr = wr + sz;
        end else if (rd > sz) begin
          st = ST_OK; wm = wr; wr = sz; len = sz;
        end
      end else if (rd - wr > sz) begin
        st = ST_OK; start = wr; len = sz; wr = wr + sz;
      end
    end else if (wr == rd) begin
      st = ST_EMPTY;
    end else begin
      // wrap mark reached: read side goes back to the start
      if (rd == wm) begin
        rd = 0;
        wm = 0;
      end
      if (wr == rd) begin
        st = ST_EMPTY;
      end else begin
        if (wr > rd) len = (wr - rd < sz) ? wr - rd : sz;
        else if (wm > rd) len = (wm - rd < sz) ? wm - rd : sz;
        else len = 0;
        st = ST_OK;
        start = rd;
        rd = rd + len;
      end
    end
    read_pos = rd[17:0];
    write_pos = wr[17:0];
    wrap_at = wm[17:0];
    g.status = st;
    g.offset = (start >= RING_BYTES) ? '0 : start[OFFSET_W-1:0];
    g.length = len[LENGTH_W-1:0];
    return g;
  endfunction

  function automatic logic [AMOUNT_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return AMOUNT_W'($urandom_range(0, 8191));
    if (r < 80) return AMOUNT_W'($urandom_range(0, 65535));
    if (r < 92) return AMOUNT_W'($urandom_range(90000, RING_BYTES));
    unique case ($urandom_range(0, 3))
      0: return AMOUNT_W'(0);
      1: return AMOUNT_W'(1);
      2: return AMOUNT_W'(RING_BYTES - 1);
      default: return AMOUNT_W'(RING_BYTES);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // compare results first, then record the word accepted at the same edge
  always @(posedge clk) begin
    grant_t g;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("variable_record_ring_allocator_unit_test failed");
      $finish;
    end
    if (rst) begin
      read_pos = '0;
      write_pos = '0;
      wrap_at = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("unexpected word, status", int'(status), 0);
        end else begin
          g = pending_grants.pop_front();
          if (status !== g.status)
            report_mismatch("status", int'(status), int'(g.status));
          if (offset !== g.offset)
            report_mismatch("offset", int'(offset), int'(g.offset));
          if (length !== g.length)
            report_mismatch("length", int'(length), int'(g.length));
        end
      end
      if (in_valid && !in_stall) begin
        g = ring_grant(func, amount);
        pending_grants.push_back(word_fixed ? word_fixed_grant : g);
      end
    end
  end

  task automatic send_word(logic f, logic [AMOUNT_W-1:0] a, logic fx, grant_t fg, int idx);
    int gap;
    gap = 0;
    if (!quiet_tail && !(long_hold_go && !long_hold_done) && (idx % 200) < 140 &&
        $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = f;
    amount = a;
    word_fixed = fx;
    word_fixed_grant = fg;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int     idx;
    grant_t none;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_PUSH;
    amount = '0;
    word_fixed = 1'b0;
    word_fixed_grant = '0;
    errors = 0;
    cycles = 0;
    long_hold_go = 0;
    long_hold_done = 0;
    quiet_tail = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    for (idx = 0; idx < N_TABLE; idx++)
      send_word(directed_rows[idx].func, directed_rows[idx].amount,
                directed_rows[idx].fixed, directed_rows[idx].grant, idx);
    for (idx = 0; idx < N_RANDOM; idx++) begin
      if (idx == 350) long_hold_go = 1;
      if (idx == 700) begin
        in_valid = 1'b0;
        while (pending_grants.size() != 0) @(negedge clk);
      end
      if (idx >= N_RANDOM - QUIET_TAIL) quiet_tail = 1;
      send_word($urandom_range(0, 1) ? FUNC_PULL : FUNC_PUSH, pick_amount(), 1'b0, none,
                idx);
    end
    in_valid = 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("variable_record_ring_allocator_unit_test passed");
    end else begin
      $display("variable_record_ring_allocator_unit_test failed");
    end
    $finish;
  end

  initial begin
    int hold_cnt;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_go && !long_hold_done) begin
        // long hold so the block fills and stalls its input
        out_stall = 1'b1;
        hold_cnt = 0;
        while (hold_cnt < LONG_HOLD) begin
          @(negedge clk);
          hold_cnt++;
        end
        long_hold_done = 1;
        out_stall = 1'b0;
      end else if (!rst && !quiet_tail && (cycles / 1000) % 3 != 2 &&
                   $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

endmodule

[filelist.f]
sv/vrra_pkg.sv
sv/variable_record_ring_allocator_unit.sv
test/variable_record_ring_allocator_unit_test.sv
